### sv/framed_crc32_frame_checker_unit_assert.svh
// Assertion macros shared by the frame checker RTL.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef FRAMED_CRC32_FRAME_CHECKER_UNIT_ASSERT_SVH
`define FRAMED_CRC32_FRAME_CHECKER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Property checked on every rising clock edge outside reset.
`define FCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("frame checker assertion failed");

// Condition that must never be true outside reset.
`define FCC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("frame checker forbidden condition seen");

`else

`define FCC_ASSERT(lbl, prop)
`define FCC_ASSERT_NEVER(lbl, cond)

`endif

`endif

### sv/fcc_pkg.sv
// Shared types, constants and CRC-32 functions of the framed CRC frame checker.
// Depends on nothing; used by fcc_frame_fsm and the top level.
package fcc_pkg;

  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [7:0] StartMarkerReset    = 8'hAA;
  localparam logic [7:0] ExpectedLengthReset = 8'd34;

  // Configuration register indexes.
  localparam logic CfgStartMarker    = 1'b0;
  localparam logic CfgExpectedLength = 1'b1;

  typedef logic [31:0][31:0] crc_cols_t;

  typedef struct packed {
    logic        crc_ok;
    logic        length_unexpected;
    logic [7:0]  payload_length;
    logic [31:0] crc_received;
    logic [31:0] crc_computed;
  } result_t;

  // Response of the 32-shift CRC step to each single input bit. Evaluated
  // only while elaborating the column table below.
  function automatic crc_cols_t crc_columns();
    crc_cols_t   cols;
    logic [31:0] c;
    for (int i = 0; i < 32; i++) begin
      c = 32'h1 << i;
      for (int k = 0; k < 32; k++) begin
        c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t CrcCols = crc_columns();

  // One word update, MSB first, as a flat XOR matrix over the column table.
  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
    logic [31:0] x;
    logic [31:0] r;
    x = crc ^ word;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        r = r ^ CrcCols[i];
      end
    end
    return r;
  endfunction

endpackage

### sv/framed_crc32_frame_checker_unit.sv
// Top level of the framed CRC-32 frame checker: handshakes, config, registers.
// Depends on fcc_pkg, fcc_frame_fsm and framed_crc32_frame_checker_unit_assert.svh.
//
// The checker takes one received byte per transaction and looks for a frame:
// the start marker byte, a length byte L, L payload bytes and four CRC bytes
// sent least significant byte first. Payload bytes are packed little-endian
// into 32-bit words (a last partial word is zero-padded), and each word runs
// through a CRC-32 with polynomial 0x04C11DB7, initial value all ones, word
// fed MSB first, no reflection and no final XOR; an empty payload gives a
// computed CRC of zero. After the fourth CRC byte one result transaction
// carries the match flag, the length mismatch flag against expected_length,
// the length byte and both CRC values. A marker byte inside a frame is data.
// The block sustains one byte per clock cycle while the result channel is
// not stalled: an accepted byte is held in an input register, is parsed and
// folded into the CRC when the parser steps, and a result is captured in an
// output register, raising out_valid_o, when the last CRC byte is parsed. The
// whole 32-bit word update is a combinational XOR matrix and sets the
// critical path. The held byte is parsed only while the result register is
// empty or being emptied in the same cycle, so input ready drops whenever a
// byte is held and a finished result is stalled on the output side. Config
// writes (index 0 start_marker, index 1 expected_length) take effect at
// once and should be made while no frame is in flight.
`include "framed_crc32_frame_checker_unit_assert.svh"

module framed_crc32_frame_checker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        crc_ok_o,
  output logic        length_unexpected_o,
  output logic [7:0]  payload_length_o,
  output logic [31:0] crc_received_o,
  output logic [31:0] crc_computed_o,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic [7:0]       start_marker_q, start_marker_d;
  logic [7:0]       expected_length_q, expected_length_d;

  logic             in_valid_q, in_valid_d;
  logic [7:0]       rx_byte_q, rx_byte_d;

  logic             out_valid_q, out_valid_d;
  fcc_pkg::result_t out_q, out_d;

  logic             step;
  logic             res_valid;
  fcc_pkg::result_t res;

  // The parser consumes the held byte whenever the result slot is free or
  // is being emptied in this same cycle.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_comb begin
    start_marker_d    = start_marker_q;
    expected_length_d = expected_length_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        fcc_pkg::CfgStartMarker:    start_marker_d    = cfg_wdata_i;
        fcc_pkg::CfgExpectedLength: expected_length_d = cfg_wdata_i;
        default: begin
          start_marker_d = start_marker_q;
        end
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    rx_byte_d  = rx_byte_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
      rx_byte_d  = rx_byte_i;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (step && res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  fcc_frame_fsm u_frame_fsm (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .rx_byte_i         (rx_byte_q),
    .start_marker_i    (start_marker_q),
    .expected_length_i (expected_length_q),
    .res_valid_o       (res_valid),
    .res_o             (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q    <= fcc_pkg::StartMarkerReset;
      expected_length_q <= fcc_pkg::ExpectedLengthReset;
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      start_marker_q    <= start_marker_d;
      expected_length_q <= expected_length_d;
      in_valid_q        <= in_valid_d;
      out_valid_q       <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    rx_byte_q <= rx_byte_d;
    out_q     <= out_d;
  end

  assign out_valid_o         = out_valid_q;
  assign crc_ok_o            = out_q.crc_ok;
  assign length_unexpected_o = out_q.length_unexpected;
  assign payload_length_o    = out_q.payload_length;
  assign crc_received_o      = out_q.crc_received;
  assign crc_computed_o      = out_q.crc_computed;

  // A held byte that could not be parsed must still be there next cycle.
  `FCC_ASSERT(a_held_byte_kept, in_valid_q && !step |=> in_valid_q && $stable(rx_byte_q))
  // A new result only ever comes from a parse step that finished a frame.
  `FCC_ASSERT(a_result_from_step, $rose(out_valid_q) |-> $past(step && res_valid))
  // A result must never be produced while the pending one is stalled.
  `FCC_ASSERT_NEVER(a_no_overwrite, step && res_valid && out_valid_q && !out_ready_i)

endmodule

### sv/fcc_frame_fsm.sv
// Frame parser and CRC accumulator of the frame checker: one byte per step.
// Depends on fcc_pkg and framed_crc32_frame_checker_unit_assert.svh.
`include "framed_crc32_frame_checker_unit_assert.svh"

module fcc_frame_fsm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       start_marker_i,
  input  logic [7:0]       expected_length_i,
  output logic             res_valid_o,
  output fcc_pkg::result_t res_o
);

  typedef enum logic [1:0] {
    PhHunt,
    PhLen,
    PhData,
    PhTail
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  byte_idx_q, byte_idx_d;
  logic [7:0]  pay_len_q, pay_len_d;
  logic [23:0] word_acc_q, word_acc_d;
  logic [1:0]  bytes_in_word_q, bytes_in_word_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rx_crc_q, rx_crc_d;

  logic [31:0] word;
  logic [7:0]  idx_inc;
  logic        last_data;
  logic [31:0] rx_crc_new;

  assign word       = {8'h00, word_acc_q} | ({24'h0, rx_byte_i} << {bytes_in_word_q, 3'b000});
  assign idx_inc    = byte_idx_q + 8'd1;
  assign last_data  = (idx_inc == pay_len_q);
  assign rx_crc_new = rx_crc_q | ({24'h0, rx_byte_i} << {byte_idx_q[1:0], 3'b000});

  always_comb begin
    phase_d         = phase_q;
    byte_idx_d      = byte_idx_q;
    pay_len_d       = pay_len_q;
    word_acc_d      = word_acc_q;
    bytes_in_word_d = bytes_in_word_q;
    crc_d           = crc_q;
    rx_crc_d        = rx_crc_q;
    res_valid_o     = 1'b0;

    res_o.crc_computed      = (pay_len_q == 8'd0) ? 32'h0 : crc_q;
    res_o.crc_received      = rx_crc_new;
    res_o.crc_ok            = (rx_crc_new == res_o.crc_computed);
    res_o.length_unexpected = (pay_len_q != expected_length_i);
    res_o.payload_length    = pay_len_q;

    if (step_i) begin
      case (phase_q)
        PhHunt: begin
          if (rx_byte_i == start_marker_i) begin
            phase_d         = PhLen;
            byte_idx_d      = 8'd0;
            word_acc_d      = '0;
            bytes_in_word_d = 2'd0;
            crc_d           = fcc_pkg::CrcInit;
            rx_crc_d        = '0;
          end
        end
        PhLen: begin
          pay_len_d  = rx_byte_i;
          byte_idx_d = 8'd0;
          phase_d    = (rx_byte_i == 8'd0) ? PhTail : PhData;
        end
        PhData: begin
          byte_idx_d = idx_inc;
          if (bytes_in_word_q == 2'd3 || last_data) begin
            crc_d           = fcc_pkg::crc_word(crc_q, word);
            word_acc_d      = '0;
            bytes_in_word_d = 2'd0;
          end else begin
            word_acc_d      = word[23:0];
            bytes_in_word_d = bytes_in_word_q + 2'd1;
          end
          if (last_data) begin
            byte_idx_d = 8'd0;
            phase_d    = PhTail;
          end
        end
        PhTail: begin
          rx_crc_d   = rx_crc_new;
          byte_idx_d = idx_inc;
          if (byte_idx_q[1:0] == 2'd3) begin
            res_valid_o = 1'b1;
            phase_d     = PhHunt;
            byte_idx_d  = 8'd0;
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PhHunt;
      byte_idx_q      <= 8'd0;
      pay_len_q       <= 8'd0;
      word_acc_q      <= '0;
      bytes_in_word_q <= 2'd0;
      crc_q           <= fcc_pkg::CrcInit;
      rx_crc_q        <= '0;
    end else begin
      phase_q         <= phase_d;
      byte_idx_q      <= byte_idx_d;
      pay_len_q       <= pay_len_d;
      word_acc_q      <= word_acc_d;
      bytes_in_word_q <= bytes_in_word_d;
      crc_q           <= crc_d;
      rx_crc_q        <= rx_crc_d;
    end
  end

  // A finished frame always sends the parser back to hunting.
  `FCC_ASSERT(a_res_then_hunt, res_valid_o |=> phase_q == PhHunt)
  // The payload counter never reaches the length inside the payload.
  `FCC_ASSERT(a_data_idx_below_len, phase_q == PhData |-> byte_idx_q < pay_len_q)
  // No partial word survives outside the payload phase.
  `FCC_ASSERT(a_no_stale_partial, phase_q != PhData |-> bytes_in_word_q == 2'd0)

endmodule
